// ----- design/idq_pkg.sv -----
// Package: shared types, constants and sizing functions for the indexed deque.
`timescale 1ns / 1ps

package idq_pkg;

   // Store geometry
   localparam int DEPTH   = 512;
   localparam int REC_W   = 64;
   localparam int INDEX_W = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W   = (COUNT_W > 9) ? COUNT_W : 9;

   // Field widths of the stream payloads
   localparam int CMD_W    = 3;
   localparam int POS_W    = 9;
   localparam int REC_IO_W = 64;
   localparam int STAT_W   = 2;
   localparam int CNT_IO_W = 10;
   localparam int REQ_W    = 80;
   localparam int RSP_W    = 80;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INSERT_AFTER = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DELETE_AT    = 3'd5;

   // Status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // Per-cell operation broadcast along the chain
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [INDEX_W-1:0] slot;
   } cell_ctl_type;

   // Readout tree: OR of FANIN children per node, one register level each
   localparam int FANIN = 8;

   function automatic int node_count(input int lvl);
      int n;
      n = DEPTH;
      for (int j = 0; j < lvl; j++) begin
         n = (n + FANIN - 1) / FANIN;
      end
      return n;
   endfunction

   function automatic int tree_levels();
      int n;
      int l;
      n = DEPTH;
      l = 0;
      for (int j = 0; j < 32; j++) begin
         if (n > 1) begin
            n = (n + FANIN - 1) / FANIN;
            l = l + 1;
         end
      end
      return (l < 1) ? 1 : l;
   endfunction

   // Offset of the first output node of level lvl in the flat node array
   function automatic int node_offset(input int lvl);
      int s;
      s = 0;
      for (int j = 1; j <= lvl; j++) begin
         s = s + node_count(j);
      end
      return s;
   endfunction

   localparam int TREE_LEVELS = tree_levels();
   localparam int TREE_NODES  = node_offset(TREE_LEVELS);
   localparam int LVL_W       = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

endpackage

// ----- design/idq_cell.sv -----
// Module: one storage cell of the shifting record chain.
`timescale 1ns / 1ps

module idq_cell (
   input  logic                           clock,
   input  idq_pkg::cell_ctl_type          ctl,
   input  logic [idq_pkg::INDEX_W-1:0]    cell_index,
   input  logic [idq_pkg::REC_W-1:0]      from_left,
   input  logic [idq_pkg::REC_W-1:0]      from_right,
   input  logic [idq_pkg::REC_W-1:0]      record,
   output logic [idq_pkg::REC_W-1:0]      value,
   output logic [idq_pkg::REC_W-1:0]      pick
);

   logic [idq_pkg::REC_W-1:0] value_ff;
   logic [idq_pkg::REC_W-1:0] value_in;
   logic                      at_slot;
   logic                      above_slot;

   assign at_slot    = (cell_index == ctl.slot);
   assign above_slot = (cell_index > ctl.slot);

   always_comb begin
      value_in = value_ff;
      unique case (ctl.op)
         idq_pkg::OP_INSERT: begin
            if (above_slot) begin
               value_in = from_left;
            end else if (at_slot) begin
               value_in = record;
            end
         end
         idq_pkg::OP_REMOVE: begin
            if (above_slot || at_slot) begin
               value_in = from_right;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   // Offer the old contents to the readout tree when this cell is removed
   assign pick  = (ctl.op == idq_pkg::OP_REMOVE && at_slot) ? value_ff : '0;

endmodule

// ----- design/idq_tree.sv -----
// Module: registered OR tree that collects the record picked out of the chain.
`timescale 1ns / 1ps

module idq_tree (
   input  logic                      clock,
   input  logic [idq_pkg::REC_W-1:0] leaf [idq_pkg::DEPTH],
   output logic [idq_pkg::REC_W-1:0] root
);

   logic [idq_pkg::REC_W-1:0] node_w [idq_pkg::TREE_NODES];

   for (genvar k = 0; k < idq_pkg::TREE_LEVELS; k++) begin : g_level
      localparam int N_IN    = idq_pkg::node_count(k);
      localparam int N_OUT   = idq_pkg::node_count(k + 1);
      localparam int OFF_OUT = idq_pkg::node_offset(k);

      for (genvar g = 0; g < N_OUT; g++) begin : g_node
         logic [idq_pkg::REC_W-1:0] child [idq_pkg::FANIN];
         logic [idq_pkg::REC_W-1:0] node_in;
         logic [idq_pkg::REC_W-1:0] node_ff;

         for (genvar j = 0; j < idq_pkg::FANIN; j++) begin : g_child
            if (g * idq_pkg::FANIN + j >= N_IN) begin : g_pad
               assign child[j] = '0;
            end else if (k == 0) begin : g_leaf
               assign child[j] = leaf[g * idq_pkg::FANIN + j];
            end else begin : g_inner
               localparam int OFF_IN = idq_pkg::node_offset(k - 1);
               assign child[j] = node_w[OFF_IN + g * idq_pkg::FANIN + j];
            end
         end

         always_comb begin
            node_in = '0;
            for (int j = 0; j < idq_pkg::FANIN; j++) begin
               node_in = node_in | child[j];
            end
         end

         always_ff @(posedge clock) begin
            node_ff <= node_in;
         end

         assign node_w[OFF_OUT + g] = node_ff;
      end
   end

   assign root = node_w[idq_pkg::TREE_NODES - 1];

endmodule

// ----- design/indexed_deque.sv -----
// Module: top level of the indexed deque, a bounded record sequence in a cell chain.
`timescale 1ns / 1ps

// Channel   Direction  Payload (lowest bit first)                               Handshake
// req_      in         command[2:0] position[11:3] record_in[75:12] zero[79:76] tvalid/tready
// rsp_      out        status[1:0] record_out[65:2] element_count[75:66] zero    tvalid/tready
//
// After acceptance the chain shifts in the execute state, then the removed record
// climbs the registered OR tree over the cells, eight children per level. A new
// request is taken only once the last one has been handed to the output register.
// Reset (synchronous, active high) empties the sequence; cell contents stay as they are.
// A response waiting in the output register does not block the next request; only
// the hand-over of a finished request into that register stalls on rsp_tready.

module indexed_deque (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [idq_pkg::REQ_W-1:0]   req_tdata,  // command, position, record_in, zero fill
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [idq_pkg::RSP_W-1:0]   rsp_tdata   // status, record_out, element_count, zero fill
);

   // Sequencer codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]                        state_ff;
   logic [1:0]                        state_in;
   logic [idq_pkg::LVL_W-1:0]         wait_ff;
   logic [idq_pkg::LVL_W-1:0]         wait_in;
   logic [idq_pkg::COUNT_W-1:0]       count_ff;
   logic [idq_pkg::COUNT_W-1:0]       count_in;
   logic [idq_pkg::STAT_W-1:0]        status_ff;
   logic [idq_pkg::STAT_W-1:0]        status_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [idq_pkg::RSP_W-1:0]         rsp_data_ff;
   logic [idq_pkg::RSP_W-1:0]         rsp_data_in;

   // Request held for the execute cycle
   logic [idq_pkg::CMD_W-1:0]         cmd_ff;
   logic [idq_pkg::POS_W-1:0]         pos_ff;
   logic [idq_pkg::REC_W-1:0]         rec_ff;
   logic [idq_pkg::REC_W-1:0]         removed_ff;

   logic                              req_take;
   logic                              rsp_free;
   logic                              empty;
   logic                              full;
   logic [idq_pkg::COUNT_W-1:0]       last;
   logic [idq_pkg::CMP_W-1:0]         pos_ext;
   logic [idq_pkg::CMP_W-1:0]         last_ext;
   logic [idq_pkg::CMP_W-1:0]         clamp;
   idq_pkg::cell_ctl_type             ctl;
   idq_pkg::cell_ctl_type             exec_ctl;

   logic [idq_pkg::REC_W-1:0]         value_w [idq_pkg::DEPTH];
   logic [idq_pkg::REC_W-1:0]         pick_w  [idq_pkg::DEPTH];
   logic [idq_pkg::REC_W-1:0]         root_w;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Latch the request fields
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= req_tdata[2:0];
         pos_ff <= req_tdata[11:3];
         rec_ff <= req_tdata[12 +: idq_pkg::REC_W];
      end
   end

   // Decode the command against the current count
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == idq_pkg::COUNT_W'(idq_pkg::DEPTH));
   assign last     = count_ff - idq_pkg::COUNT_W'(1);
   assign pos_ext  = idq_pkg::CMP_W'(pos_ff);
   assign last_ext = idq_pkg::CMP_W'(last);
   assign clamp    = (pos_ext > last_ext) ? last_ext : pos_ext;

   always_comb begin
      exec_ctl.op   = idq_pkg::OP_HOLD;
      exec_ctl.slot = '0;
      status_in     = idq_pkg::ST_DONE;
      count_in      = count_ff;
      unique case (cmd_ff)
         idq_pkg::CMD_PUSH_FRONT, idq_pkg::CMD_PUSH_BACK: begin
            if (full) begin
               status_in = idq_pkg::ST_FULL;
            end else begin
               exec_ctl.op   = idq_pkg::OP_INSERT;
               exec_ctl.slot = (cmd_ff == idq_pkg::CMD_PUSH_FRONT) ? '0
                             : count_ff[idq_pkg::INDEX_W-1:0];
               count_in      = count_ff + idq_pkg::COUNT_W'(1);
            end
         end
         idq_pkg::CMD_POP_FRONT, idq_pkg::CMD_POP_BACK: begin
            if (empty) begin
               status_in = idq_pkg::ST_EMPTY;
            end else begin
               exec_ctl.op   = idq_pkg::OP_REMOVE;
               exec_ctl.slot = (cmd_ff == idq_pkg::CMD_POP_FRONT) ? '0
                             : last[idq_pkg::INDEX_W-1:0];
               count_in      = last;
            end
         end
         idq_pkg::CMD_INSERT_AFTER: begin
            if (empty) begin
               status_in = idq_pkg::ST_EMPTY;
            end else if (full) begin
               status_in = idq_pkg::ST_FULL;
            end else begin
               // Inserting after the tail lands in the first free cell
               exec_ctl.op   = idq_pkg::OP_INSERT;
               exec_ctl.slot = idq_pkg::INDEX_W'(clamp + idq_pkg::CMP_W'(1));
               count_in      = count_ff + idq_pkg::COUNT_W'(1);
            end
         end
         idq_pkg::CMD_DELETE_AT: begin
            if (empty) begin
               status_in = idq_pkg::ST_EMPTY;
            end else begin
               exec_ctl.op   = idq_pkg::OP_REMOVE;
               exec_ctl.slot = clamp[idq_pkg::INDEX_W-1:0];
               count_in      = last;
            end
         end
         default: begin
            // unused command codes: report done and change nothing
            status_in = idq_pkg::ST_DONE;
         end
      endcase
   end

   // Broadcast to the chain only in the execute cycle
   always_comb begin
      ctl = exec_ctl;
      if (state_ff != S_EXEC) begin
         ctl.op = idq_pkg::OP_HOLD;
      end
   end

   // Cell chain: each cell shifts from its neighbour, loads the record or holds
   for (genvar i = 0; i < idq_pkg::DEPTH; i++) begin : g_cell
      logic [idq_pkg::REC_W-1:0] left_w;
      logic [idq_pkg::REC_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = value_w[i-1];
      end
      if (i == idq_pkg::DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = value_w[i+1];
      end

      idq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_index (idq_pkg::INDEX_W'(i)),
         .from_left  (left_w),
         .from_right (right_w),
         .record     (rec_ff),
         .value      (value_w[i]),
         .pick       (pick_w[i])
      );
   end

   // Collect the removed record; zero when nothing was removed
   idq_tree u_tree (
      .clock (clock),
      .leaf  (pick_w),
      .root  (root_w)
   );

   // Sequencer: execute, let the tree settle, then hand over to the output register
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_WAIT;
            wait_in  = idq_pkg::LVL_W'(idq_pkg::TREE_LEVELS - 1);
         end
         S_WAIT: begin
            if (wait_ff == '0) begin
               state_in = S_DONE;
            end else begin
               wait_in = wait_ff - idq_pkg::LVL_W'(1);
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, idq_pkg::CNT_IO_W'(count_ff),
                               idq_pkg::REC_IO_W'(removed_ff), status_ff};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_EXEC) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (state_ff == S_EXEC) begin
         status_ff <= status_in;
      end
      if (state_ff == S_WAIT && wait_ff == '0) begin
         removed_ff <= root_w;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= idq_pkg::COUNT_W'(idq_pkg::DEPTH))
      else $error("element count beyond store depth");

   // A failing command leaves the count as it was
   a_fail_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && status_in != idq_pkg::ST_DONE) |=> $stable(count_ff))
      else $error("failed command changed the count");

   // An accepted request goes straight to the execute cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_EXEC))
      else $error("accepted request did not execute");

   // A finished request with a free output register is handed over at once
   a_handover: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished request not handed over");

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the indexed deque: self-checking stream test against a queue-based predictor.
`timescale 1ns / 1ps

module tb_top;

   // Command codes that the block treats as no-ops
   localparam logic [idq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [idq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam int IDLE_PCT    = 36;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 4 * (idq_pkg::TREE_LEVELS + 3);

   typedef struct packed {
      logic [idq_pkg::CMD_W-1:0]    command;
      logic [idq_pkg::POS_W-1:0]    position;
      logic [idq_pkg::REC_IO_W-1:0] record_in;
   } deque_cmd_type;

   typedef struct packed {
      logic [idq_pkg::STAT_W-1:0]   status;
      logic [idq_pkg::REC_IO_W-1:0] record_out;
      logic [idq_pkg::CNT_IO_W-1:0] element_count;
   } deque_rsp_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [idq_pkg::REQ_W-1:0] req_tdata  = '0;   // command, position, record_in, zero fill
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [idq_pkg::RSP_W-1:0] rsp_tdata;         // status, record_out, element_count, zero fill

   // Predictor state: slot 0 of the queue is the front of the sequence
   logic [idq_pkg::REC_W-1:0] deque_model[$];
   deque_rsp_type             pending_rsp[$];

   bit steady_flow  = 1'b0;
   int fail_count   = 0;
   int cycle_count  = 0;
   int n_requests   = 0;
   int n_done       = 0;
   int n_empty      = 0;
   int n_full       = 0;
   int peak_count   = 0;

   indexed_deque i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Apply one request to the predictor and return the response it must produce
   function automatic deque_rsp_type apply_to_model(input deque_cmd_type cmd);
      deque_rsp_type r;
      int unsigned   slot;
      r.status     = idq_pkg::ST_DONE;
      r.record_out = '0;
      case (cmd.command)
         idq_pkg::CMD_PUSH_FRONT, idq_pkg::CMD_PUSH_BACK: begin
            if (deque_model.size() >= idq_pkg::DEPTH) begin
               r.status = idq_pkg::ST_FULL;
            end else if (cmd.command == idq_pkg::CMD_PUSH_FRONT) begin
               deque_model.push_front(cmd.record_in[idq_pkg::REC_W-1:0]);
            end else begin
               deque_model.push_back(cmd.record_in[idq_pkg::REC_W-1:0]);
            end
         end
         idq_pkg::CMD_POP_FRONT, idq_pkg::CMD_POP_BACK: begin
            if (deque_model.size() == 0) begin
               r.status = idq_pkg::ST_EMPTY;
            end else if (cmd.command == idq_pkg::CMD_POP_FRONT) begin
               r.record_out = deque_model.pop_front();
            end else begin
               r.record_out = deque_model.pop_back();
            end
         end
         idq_pkg::CMD_INSERT_AFTER: begin
            if (deque_model.size() == 0) begin
               r.status = idq_pkg::ST_EMPTY;
            end else if (deque_model.size() >= idq_pkg::DEPTH) begin
               r.status = idq_pkg::ST_FULL;
            end else begin
               // a position past the end clamps to the last element
               slot = (cmd.position >= deque_model.size()) ? deque_model.size() - 1
                                                            : cmd.position;
               slot = slot + 1;
               if (slot == deque_model.size()) begin
                  deque_model.push_back(cmd.record_in[idq_pkg::REC_W-1:0]);
               end else begin
                  deque_model.insert(slot, cmd.record_in[idq_pkg::REC_W-1:0]);
               end
            end
         end
         idq_pkg::CMD_DELETE_AT: begin
            if (deque_model.size() == 0) begin
               r.status = idq_pkg::ST_EMPTY;
            end else begin
               slot = (cmd.position >= deque_model.size()) ? deque_model.size() - 1
                                                            : cmd.position;
               r.record_out = deque_model[slot];
               deque_model.delete(slot);
            end
         end
         default: ;
      endcase
      r.element_count = idq_pkg::CNT_IO_W'(deque_model.size());
      return r;
   endfunction

   function automatic deque_cmd_type make_cmd(
         input logic [idq_pkg::CMD_W-1:0]    command,
         input logic [idq_pkg::POS_W-1:0]    position,
         input logic [idq_pkg::REC_IO_W-1:0] record_in);
      deque_cmd_type c;
      c.command   = command;
      c.position  = position;
      c.record_in = record_in;
      return c;
   endfunction

   // Draw a request that grows the sequence with probability grow_pct
   function automatic deque_cmd_type random_request(input int grow_pct);
      deque_cmd_type c;
      if ($urandom_range(0, 99) < grow_pct) begin
         case ($urandom_range(0, 2))
            0:       c.command = idq_pkg::CMD_PUSH_FRONT;
            1:       c.command = idq_pkg::CMD_PUSH_BACK;
            default: c.command = idq_pkg::CMD_INSERT_AFTER;
         endcase
      end else begin
         case ($urandom_range(0, 2))
            0:       c.command = idq_pkg::CMD_POP_FRONT;
            1:       c.command = idq_pkg::CMD_POP_BACK;
            default: c.command = idq_pkg::CMD_DELETE_AT;
         endcase
      end
      // half the positions land inside the sequence, the rest anywhere in range
      if (deque_model.size() > 0 && $urandom_range(0, 1) == 1) begin
         c.position = idq_pkg::POS_W'($urandom_range(0, deque_model.size() - 1));
      end else begin
         c.position = idq_pkg::POS_W'($urandom_range(0, (1 << idq_pkg::POS_W) - 1));
      end
      c.record_in = {$urandom, $urandom};
      return c;
   endfunction

   // Present one request, hold it until accepted, then log its expected response
   task automatic send_request(input deque_cmd_type cmd);
      deque_rsp_type exp_rsp;
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(idq_pkg::REQ_W - idq_pkg::CMD_W - idq_pkg::POS_W
                       - idq_pkg::REC_IO_W){1'b0}},
                     cmd.record_in, cmd.position, cmd.command};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      exp_rsp = apply_to_model(cmd);
      pending_rsp.push_back(exp_rsp);
      n_requests++;
      case (exp_rsp.status)
         idq_pkg::ST_EMPTY: n_empty++;
         idq_pkg::ST_FULL:  n_full++;
         default:           n_done++;
      endcase
      if (deque_model.size() > peak_count) begin
         peak_count = deque_model.size();
      end
   endtask

   // Drop valid and hold off until every outstanding response has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Run n_items random requests; spare commands are sprinkled in as noise
   task automatic run_random(input int n_items, input int grow_pct);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 3) begin
            send_request(make_cmd($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO,
                                  idq_pkg::POS_W'($urandom_range(0,
                                     (1 << idq_pkg::POS_W) - 1)),
                                  {$urandom, $urandom}));
         end else begin
            send_request(random_request(grow_pct));
            sent++;
         end
      end
   endtask

   task automatic test_empty_errors();
      send_request(make_cmd(idq_pkg::CMD_POP_FRONT,    9'd0,   64'h0));
      send_request(make_cmd(idq_pkg::CMD_POP_BACK,     9'd511, {64{1'b1}}));
      send_request(make_cmd(idq_pkg::CMD_INSERT_AFTER, 9'd511, {64{1'b1}}));
      send_request(make_cmd(idq_pkg::CMD_DELETE_AT,    9'd0,   64'h0));
      send_request(make_cmd(CMD_SPARE_LO,              9'd511, {64{1'b1}}));
      wait_for_drain();
   endtask

   task automatic test_edge_positions();
      send_request(make_cmd(idq_pkg::CMD_PUSH_FRONT,   9'd0,   64'h0));
      send_request(make_cmd(idq_pkg::CMD_PUSH_BACK,    9'd511, {64{1'b1}}));
      send_request(make_cmd(idq_pkg::CMD_PUSH_FRONT,   9'd170, 64'h0123_4567_89ab_cdef));
      send_request(make_cmd(idq_pkg::CMD_INSERT_AFTER, 9'd0,   64'hfedc_ba98_7654_3210));
      // past the end: the new record must become the tail
      send_request(make_cmd(idq_pkg::CMD_INSERT_AFTER, 9'd511, 64'h5555_5555_5555_5555));
      send_request(make_cmd(idq_pkg::CMD_INSERT_AFTER, 9'd4,   64'haaaa_aaaa_aaaa_aaaa));
      send_request(make_cmd(idq_pkg::CMD_POP_BACK,     9'd0,   64'h0));
      send_request(make_cmd(idq_pkg::CMD_DELETE_AT,    9'd511, 64'h0));
      send_request(make_cmd(idq_pkg::CMD_DELETE_AT,    9'd1,   64'h0));
      send_request(make_cmd(CMD_SPARE_HI,              9'd0,   64'h0));
      send_request(make_cmd(idq_pkg::CMD_DELETE_AT,    9'd0,   64'h0));
      send_request(make_cmd(idq_pkg::CMD_POP_FRONT,    9'd511, 64'h0));
      send_request(make_cmd(idq_pkg::CMD_POP_FRONT,    9'd0,   64'h0));
      send_request(make_cmd(idq_pkg::CMD_POP_BACK,     9'd0,   64'h0));
      wait_for_drain();
   endtask

   // Grow until the store is full, then hammer it with growing requests
   task automatic test_fill_to_full();
      int guard;
      guard = 0;
      while (deque_model.size() < idq_pkg::DEPTH && guard < 800) begin
         run_random(1, 92);
         guard++;
      end
      run_random(15, 100);
      wait_for_drain();
   endtask

   task automatic test_drain();
      run_random(250, 10);
      wait_for_drain();
   endtask

   // Back-to-back requests with the receiver always ready
   task automatic test_mixed_steady();
      steady_flow = 1'b1;
      run_random(120, 50);
      wait_for_drain();
      steady_flow = 1'b0;
   endtask

   task automatic test_mixed_stalls();
      run_random(100, 50);
      wait_for_drain();
   endtask

   // Check each accepted response against the oldest expectation; pick the next ready
   always @(posedge clock) begin
      deque_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_tdata[idq_pkg::STAT_W-1:0] !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status,
                      rsp_tdata[idq_pkg::STAT_W-1:0]);
               fail_count++;
            end
            if (rsp_tdata[idq_pkg::STAT_W +: idq_pkg::REC_IO_W] !== exp_rsp.record_out) begin
               $error("record_out: expected %h, got %h", exp_rsp.record_out,
                      rsp_tdata[idq_pkg::STAT_W +: idq_pkg::REC_IO_W]);
               fail_count++;
            end
            if (rsp_tdata[idq_pkg::STAT_W + idq_pkg::REC_IO_W +: idq_pkg::CNT_IO_W]
                !== exp_rsp.element_count) begin
               $error("element_count: expected %0d, got %0d", exp_rsp.element_count,
                      rsp_tdata[idq_pkg::STAT_W + idq_pkg::REC_IO_W +: idq_pkg::CNT_IO_W]);
               fail_count++;
            end
         end
      end
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timed out with %0d responses outstanding", pending_rsp.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_errors();
      test_edge_positions();
      test_fill_to_full();
      test_drain();
      test_mixed_steady();
      test_mixed_stalls();
      wait_for_drain();
      // allow for any stray response after the last expected one
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d expected responses never arrived", pending_rsp.size());
         fail_count++;
      end
      $display("Covered %0d requests: %0d done, %0d on empty, %0d on full.",
               n_requests, n_done, n_empty, n_full);
      $display("Peak occupancy %0d of %0d, with idle-free and stalled stretches.",
               peak_count, idq_pkg::DEPTH);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
